FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by bbs_core; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// Check that a condition never becomes true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg
// Types, constants and helper functions of the buzzer beep sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package bbs_pkg;

  localparam int unsigned IV_W    = 13;  // interval / 10 fits 13 bits
  localparam int unsigned TENTH_W = 4;   // duty tenths, 0..10

  localparam logic       REQ_TICK  = 1'b0;
  localparam logic       REQ_START = 1'b1;

  localparam logic [6:0]  FULL_PERCENT = 7'd100;
  localparam logic [15:0] DEFAULT_MS   = 16'd500;

  // x / 10 for 16-bit x: multiply by ceil(2^19 / 10), drop 19 bits
  localparam logic [15:0] RECIP_TEN_16 = 16'd52429;
  // x / 10 for x up to 100: multiply by 205, drop 11 bits
  localparam logic [7:0]  RECIP_TEN_7  = 8'd205;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         beep_count;
    logic [IV_W-1:0]    iv;
    logic [TENTH_W-1:0] on_tenths;
    logic [TENTH_W-1:0] off_tenths;
  } bbs_item_t;

  function automatic logic [IV_W-1:0] div10_u16(input logic [15:0] x);
    logic [31:0] p;
    p = {16'd0, x} * {16'd0, RECIP_TEN_16};
    return p[31:19];
  endfunction

  function automatic logic [TENTH_W-1:0] div10_pct(input logic [6:0] x);
    logic [14:0] p;
    p = {8'd0, x} * {7'd0, RECIP_TEN_7};
    return p[14:11];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/buzzer_beep_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_beep_sequencer
// Plays a train of beeps from one-millisecond ticks and start requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each beat is either a tick
//   (in_req_type = 0) or a start request carrying beep count, interval in
//   ms and duty in percent. A start while a sequence runs, or with a count
//   of zero, is dropped and reports start_accepted = 0.
//   Result channel (out_valid / out_stall): exactly one result beat per
//   input beat, in order: buzzer state, busy flag and start acceptance as
//   they stand after that beat.
//   The path holds one input register (interval and duty pre-scaled to
//   tenths there) and one result register, with the state update done
//   in the single pass between them.
//   Throughput is one beat per cycle while the result channel does not
//   stall; the state registers are the only loop.
//   When the receiver stalls, the result holds and the input register still
//   fills, so one more beat is taken before in_stall rises.
//   Synchronous reset: no sequence running, buzzer off, phase lengths back
//   to 500 ms, both pipeline stages empty.
// ----------------------------------------------------------------------------
`default_nettype none
module buzzer_beep_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_beep_count,
  input  wire logic [15:0] in_interval_ms,
  input  wire logic [6:0]  in_duty_percent,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_buzzer_enable,
  output logic             out_busy_res,
  output logic             out_start_accepted
);

  // stage 1 to core hand-off
  logic               s1_valid;
  bbs_pkg::bbs_item_t s1_item;
  logic               take;

  // capture the beat and scale interval and duty
  bbs_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_beep_count   (in_beep_count),
    .in_interval_ms  (in_interval_ms),
    .in_duty_percent (in_duty_percent),
    .s1_valid_o      (s1_valid),
    .s1_item_o       (s1_item),
    .take_i          (take)
  );

  // advance the sequencer and register the result
  bbs_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .s1_valid_i         (s1_valid),
    .s1_item_i          (s1_item),
    .take_o             (take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_buzzer_enable  (out_buzzer_enable),
    .out_busy_res       (out_busy_res),
    .out_start_accepted (out_start_accepted)
  );

endmodule
`default_nettype wire

FILE: rtl/bbs_in_stage.sv
// ----------------------------------------------------------------------------
// bbs_in_stage
// Input register: captures a beat and pre-scales interval and duty to tenths.
// ----------------------------------------------------------------------------
`default_nettype none
module bbs_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_req_type,
  input  wire logic [7:0]        in_beep_count,
  input  wire logic [15:0]       in_interval_ms,
  input  wire logic [6:0]        in_duty_percent,
  output logic                   s1_valid_o,
  output bbs_pkg::bbs_item_t     s1_item_o,
  input  wire logic              take_i
);

  logic               s1_valid_r;
  bbs_pkg::bbs_item_t item_r;
  bbs_pkg::bbs_item_t item_nxt;
  logic [6:0]         duty_sat;
  logic [6:0]         duty_rest;
  logic               accept;

  // saturate duty to full scale
  always_comb begin
    duty_sat  = (in_duty_percent > bbs_pkg::FULL_PERCENT) ? bbs_pkg::FULL_PERCENT
                                                          : in_duty_percent;
    duty_rest = bbs_pkg::FULL_PERCENT - duty_sat;
    item_nxt.req_type   = in_req_type;
    item_nxt.beep_count = in_beep_count;
    item_nxt.iv         = bbs_pkg::div10_u16(in_interval_ms);
    item_nxt.on_tenths  = bbs_pkg::div10_pct(duty_sat);
    item_nxt.off_tenths = bbs_pkg::div10_pct(duty_rest);
  end

  assign in_stall = s1_valid_r && !take_i;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign s1_valid_o = s1_valid_r;
  assign s1_item_o  = item_r;

endmodule
`default_nettype wire

FILE: rtl/bbs_core.sv
// ----------------------------------------------------------------------------
// bbs_core
// Sequencer state, single-pass update per beat and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module bbs_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s1_valid_i,
  input  wire bbs_pkg::bbs_item_t s1_item_i,
  output logic                    take_o,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_buzzer_enable,
  output logic                    out_busy_res,
  output logic                    out_start_accepted
);

  logic [7:0]  repeats_r,  repeats_nxt;
  logic [15:0] on_time_r,  on_time_nxt;
  logic [15:0] off_time_r, off_time_nxt;
  logic [15:0] remain_r,   remain_nxt;
  logic        phase_on_r, phase_on_nxt;
  logic        accepted_nxt;
  logic        load;
  logic [15:0] on_calc;
  logic [15:0] off_calc;

  logic        out_valid_r;
  logic        out_buzzer_r;
  logic        out_busy_r;
  logic        out_start_r;

  assign take_o = !out_valid_r || !out_stall;
  assign load   = s1_valid_i && take_o;

  // interval tenths (at most 6553) times duty tenths (at most 10) fits 16 bits
  assign on_calc  = {3'd0, s1_item_i.iv} * {12'd0, s1_item_i.on_tenths};
  assign off_calc = {3'd0, s1_item_i.iv} * {12'd0, s1_item_i.off_tenths};

  always_comb begin
    repeats_nxt  = repeats_r;
    on_time_nxt  = on_time_r;
    off_time_nxt = off_time_r;
    remain_nxt   = remain_r;
    phase_on_nxt = phase_on_r;
    accepted_nxt = 1'b0;
    unique case (s1_item_i.req_type)
      bbs_pkg::REQ_START: begin
        // drop starts while busy or with no beeps
        if (repeats_r == 8'd0 && s1_item_i.beep_count != 8'd0) begin
          repeats_nxt  = s1_item_i.beep_count;
          on_time_nxt  = on_calc;
          off_time_nxt = off_calc;
          phase_on_nxt = 1'b1;
          remain_nxt   = on_calc;
          accepted_nxt = 1'b1;
        end
      end
      default: begin
        if (repeats_r != 8'd0) begin
          if (remain_r > 16'd1) begin
            remain_nxt = remain_r - 16'd1;
          end else if (phase_on_r) begin
            phase_on_nxt = 1'b0;
            repeats_nxt  = repeats_r - 8'd1;
            remain_nxt   = (repeats_r != 8'd1) ? off_time_r : 16'd0;
          end else begin
            phase_on_nxt = 1'b1;
            remain_nxt   = on_time_r;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeats_r  <= 8'd0;
      on_time_r  <= bbs_pkg::DEFAULT_MS;
      off_time_r <= bbs_pkg::DEFAULT_MS;
      remain_r   <= 16'd0;
      phase_on_r <= 1'b0;
    end else if (load) begin
      repeats_r  <= repeats_nxt;
      on_time_r  <= on_time_nxt;
      off_time_r <= off_time_nxt;
      remain_r   <= remain_nxt;
      phase_on_r <= phase_on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_o) begin
      out_valid_r <= s1_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_buzzer_r <= phase_on_nxt;
      out_busy_r   <= (repeats_nxt != 8'd0);
      out_start_r  <= accepted_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_buzzer_enable  = out_buzzer_r;
  assign out_busy_res       = out_busy_r;
  assign out_start_accepted = out_start_r;

  `ASSERT_NEVER(a_on_when_idle, clk, rst_n, phase_on_r && repeats_r == 8'd0)
  `ASSERT_CLK(a_start_sounds, clk, rst_n,
              out_valid_r && out_start_r |-> out_buzzer_r && out_busy_r)
  `ASSERT_CLK(a_busy_start_dropped, clk, rst_n,
              load && s1_item_i.req_type == bbs_pkg::REQ_START && repeats_r != 8'd0
              |=> !out_start_r && $stable(repeats_r))
  `ASSERT_CLK(a_hold_without_load, clk, rst_n,
              !load |=> $stable(repeats_r) && $stable(remain_r))

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for buzzer_beep_sequencer. A short table of directed
// beats (idle ticks, dropped starts, zero-length phases, duty saturation,
// field extremes) is followed by random beep trains with random content.
// A predictor tracks the sequencer state and computes the expected result
// beat for every accepted input beat. Result beats are checked in order,
// field by field. Both channels idle and stall in random bursts.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 4;
  localparam int          RESET_CYCLES = 8;
  localparam int          RANDOM_BEATS = 750;
  localparam int          CALM_FROM    = 660;   // no idling after this beat
  localparam int          DRAIN_CYCLES = 16;
  localparam int          IDLE_LIMIT   = 2000;  // cycles with no beat moving
  localparam int unsigned TENTH        = 10;
  localparam int unsigned PCT_FULL     = bbs_pkg::FULL_PERCENT;

  // One input beat, one result beat.
  typedef struct packed {
    logic        req_type;
    logic [7:0]  beep_count;
    logic [15:0] interval_ms;
    logic [6:0]  duty_percent;
  } beep_item_t;

  typedef struct packed {
    logic buzzer_enable;
    logic busy_res;
    logic start_accepted;
  } beep_result_t;

  // Directed row: a beat plus, where it is obvious, the result typed in.
  typedef struct packed {
    logic         req_type;
    logic [7:0]   beep_count;
    logic [15:0]  interval_ms;
    logic [6:0]   duty_percent;
    logic         typed;
    beep_result_t result;
  } beat_row_t;

  localparam beep_result_t NO_RES      = 3'b000;  // row checked by the predictor
  localparam beep_result_t IDLE_RES    = 3'b000;  // silent, idle, nothing taken
  localparam beep_result_t STARTED_RES = 3'b111;  // sounding, busy, taken
  localparam beep_result_t DROPPED_ON  = 3'b110;  // sounding, busy, start dropped

  localparam int DIRECTED_N = 23;
  localparam beat_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // tick while idle: nothing moves
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b1, IDLE_RES},
    // zero count is dropped, even with every other field at its maximum
    '{bbs_pkg::REQ_START, 8'd0,   16'hFFFF,  7'd127, 1'b1, IDLE_RES},
    // one beep, interval below ten: zero-length on phase
    '{bbs_pkg::REQ_START, 8'd1,   16'd0,     7'd0,   1'b1, STARTED_RES},
    // tick carries junk payload; the zero-length on phase ends here
    '{bbs_pkg::REQ_TICK,  8'd255, 16'hFFFF,  7'd127, 1'b0, NO_RES},
    // two beeps with both phases zero long
    '{bbs_pkg::REQ_START, 8'd2,   16'd9,     7'd50,  1'b1, STARTED_RES},
    // start while busy is dropped
    '{bbs_pkg::REQ_START, 8'd255, 16'hFFFF,  7'd127, 1'b1, DROPPED_ON},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    // longest interval, duty below ten: on is zero, long off never plays
    '{bbs_pkg::REQ_START, 8'd1,   16'hFFFF,  7'd9,   1'b1, STARTED_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    // duty above a hundred saturates: 10 ms on, no off
    '{bbs_pkg::REQ_START, 8'd1,   16'd10,    7'd127, 1'b1, STARTED_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES},
    // idle again
    '{bbs_pkg::REQ_TICK,  8'd0,   16'd0,     7'd0,   1'b0, NO_RES}
  };

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input is known from time zero.
  // --------------------------------------------------------------------------
  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_req_type     = bbs_pkg::REQ_TICK;
  logic [7:0]  in_beep_count   = 8'd0;
  logic [15:0] in_interval_ms  = 16'd0;
  logic [6:0]  in_duty_percent = 7'd0;
  logic        out_stall       = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_buzzer_enable;
  logic        out_busy_res;
  logic        out_start_accepted;

  always #(CLK_PERIOD / 2) clk = ~clk;

  buzzer_beep_sequencer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_beep_count      (in_beep_count),
    .in_interval_ms     (in_interval_ms),
    .in_duty_percent    (in_duty_percent),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_buzzer_enable  (out_buzzer_enable),
    .out_busy_res       (out_busy_res),
    .out_start_accepted (out_start_accepted)
  );

  // --------------------------------------------------------------------------
  // Sequencer predictor: its own copy of the beep train state.
  // --------------------------------------------------------------------------
  logic [7:0]  seq_repeats;    // beeps still to finish; nonzero = busy
  logic [15:0] seq_on_ms;
  logic [15:0] seq_off_ms;
  logic [15:0] seq_left_ms;    // ticks left in the current phase
  logic        seq_sounding;   // on phase

  beep_result_t expected_beats [$];
  int  mismatches     = 0;
  int  results_seen   = 0;
  int  ticks_sent     = 0;
  int  starts_taken   = 0;
  int  starts_dropped = 0;
  int  beeps_played   = 0;
  bit  stim_done      = 1'b0;
  bit  calm_tail      = 1'b0;

  function automatic void reset_sequencer_model();
    seq_repeats  = 8'd0;
    seq_on_ms    = bbs_pkg::DEFAULT_MS;
    seq_off_ms   = bbs_pkg::DEFAULT_MS;
    seq_left_ms  = 16'd0;
    seq_sounding = 1'b0;
  endfunction

  // Advance the model by one beat and return the result beat it causes.
  function automatic beep_result_t predict_beat(beep_item_t it);
    beep_result_t res;
    int unsigned  tenths;
    int unsigned  pct;
    res.start_accepted = 1'b0;
    if (it.req_type == bbs_pkg::REQ_START) begin
      if (seq_repeats == 8'd0 && it.beep_count != 8'd0) begin
        tenths = int'(it.interval_ms) / TENTH;
        pct    = it.duty_percent;
        if (pct > PCT_FULL)
          pct = PCT_FULL;
        seq_repeats  = it.beep_count;
        seq_on_ms    = 16'(tenths * (pct / TENTH));
        seq_off_ms   = 16'(tenths * ((PCT_FULL - pct) / TENTH));
        seq_sounding = 1'b1;
        seq_left_ms  = seq_on_ms;
        res.start_accepted = 1'b1;
        starts_taken++;
      end else begin
        starts_dropped++;
      end
    end else begin
      ticks_sent++;
      if (seq_repeats != 8'd0) begin
        if (seq_left_ms > 16'd1) begin
          seq_left_ms = seq_left_ms - 16'd1;
        end else if (seq_sounding) begin
          // on phase over: one beep done, off phase only if more remain
          seq_sounding = 1'b0;
          seq_repeats  = seq_repeats - 8'd1;
          seq_left_ms  = (seq_repeats != 8'd0) ? seq_off_ms : 16'd0;
          beeps_played++;
        end else begin
          seq_sounding = 1'b1;
          seq_left_ms  = seq_on_ms;
        end
      end
    end
    res.buzzer_enable = seq_sounding;
    res.busy_res      = (seq_repeats != 8'd0);
    return res;
  endfunction

  // Mostly well-formed beep trains; dropped starts and junk payloads on top.
  function automatic beep_item_t make_random_beat();
    beep_item_t  it;
    int unsigned pick;
    it.req_type     = bbs_pkg::REQ_TICK;
    it.beep_count   = 8'($urandom);
    it.interval_ms  = 16'($urandom);
    it.duty_percent = 7'($urandom);
    if (seq_repeats == 8'd0) begin
      if ($urandom_range(0, 9) < 6) begin
        it.req_type = bbs_pkg::REQ_START;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          it.beep_count = 8'd0;
        end else if (pick < 10) begin
          // full count, zero-length phases keep the train short
          it.beep_count  = 8'd255;
          it.interval_ms = 16'($urandom_range(0, 9));
        end else if (pick < 20) begin
          // wide interval, zero on time, single beep
          it.beep_count   = 8'd1;
          it.duty_percent = 7'($urandom_range(0, 9));
        end else begin
          it.beep_count  = 8'($urandom_range(1, 3));
          it.interval_ms = 16'($urandom_range(0, 39));
        end
      end
    end else if ($urandom_range(0, 9) == 0) begin
      it.req_type = bbs_pkg::REQ_START;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Drive one beat, hold it until accepted, then queue its expectation.
  task automatic send_beat(input beep_item_t it, input logic typed,
                           input beep_result_t typed_res);
    int           gap;
    beep_result_t want;
    gap = 0;
    if (!calm_tail && $urandom_range(0, 4) == 0)
      gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= it.req_type;
    in_beep_count   <= it.beep_count;
    in_interval_ms  <= it.interval_ms;
    in_duty_percent <= it.duty_percent;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    want = predict_beat(it);
    if (typed)
      want = typed_res;
    expected_beats.push_back(want);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and final verdict.
  // --------------------------------------------------------------------------
  initial begin
    beep_item_t it;
    reset_sequencer_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table first.
    for (int i = 0; i < DIRECTED_N; i++) begin
      it.req_type     = DIRECTED_ROWS[i].req_type;
      it.beep_count   = DIRECTED_ROWS[i].beep_count;
      it.interval_ms  = DIRECTED_ROWS[i].interval_ms;
      it.duty_percent = DIRECTED_ROWS[i].duty_percent;
      send_beat(it, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
    end

    // Random beep trains; drop all idling near the end.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i >= CALM_FROM)
        calm_tail = 1'b1;
      send_beat(make_random_beat(), 1'b0, NO_RES);
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;

    // Wait out the pipeline, then give stray results time to show.
    while (expected_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks, %0d starts taken, %0d starts dropped, %0d beeps played.",
             ticks_sent, starts_taken, starts_dropped, beeps_played);
    $display("Compared %0d result beats, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("** buzzer_beep_sequencer: PASSED **");
    end else begin
      $display("** buzzer_beep_sequencer: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: stall in random bursts, none in the calm tail.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n || calm_tail) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      // start a stall burst; stall_left holds the rest of it
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    beep_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", results_seen));
      end else begin
        want = expected_beats.pop_front();
        if (out_buzzer_enable !== want.buzzer_enable)
          report_mismatch($sformatf("beat %0d buzzer_enable: want %0b got %0b",
                                    results_seen, want.buzzer_enable, out_buzzer_enable));
        if (out_busy_res !== want.busy_res)
          report_mismatch($sformatf("beat %0d busy_res: want %0b got %0b",
                                    results_seen, want.busy_res, out_busy_res));
        if (out_start_accepted !== want.start_accepted)
          report_mismatch($sformatf("beat %0d start_accepted: want %0b got %0b",
                                    results_seen, want.start_accepted,
                                    out_start_accepted));
      end
    end
  end

  // Watchdog: count cycles in which no beat moves while work is pending.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (stim_done && expected_beats.size() == 0)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding.",
               IDLE_LIMIT, expected_beats.size());
      $display("** buzzer_beep_sequencer: FAILED **");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bbs_pkg.sv
rtl/bbs_in_stage.sv
rtl/bbs_core.sv
rtl/buzzer_beep_sequencer.sv
bench/testbench.sv
